>>> rtl/tmtw_pkg.sv
// ----------------------------------------------------------------------------
// tmtw_pkg: shared types, constants and microprogram for the terminal writer
// Beat types, cell encoding, control-word layout and the control store.
// ----------------------------------------------------------------------------
package tmtw_pkg;

    // Default geometry
    localparam int NUM_COLUMNS_DEF = 80;
    localparam int NUM_ROWS_DEF    = 25;

    // Command codes
    localparam logic [1:0] CMD_PUT   = 2'd0;
    localparam logic [1:0] CMD_CLEAR = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Cell encoding
    localparam logic [7:0] LINE_FEED  = 8'd10;
    localparam logic [7:0] SPACE_CHAR = 8'h20;
    localparam logic [3:0] WHITE_IDX  = 4'd15;
    localparam logic [3:0] BLACK_IDX  = 4'd0;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [7:0]  char_code;
        logic [3:0]  fg_color;
        logic [3:0]  bg_color;
        logic [10:0] cell_index;
    } request_t;

    typedef struct packed {
        logic [15:0] read_data;
        logic [4:0]  row_now;
        logic [6:0]  col_now;
    } result_t;

    // Character in bits 7..0, foreground 11..8, background 15..12
    function automatic logic [15:0] make_cell(logic [7:0] ch, logic [3:0] fg,
                                              logic [3:0] bg);
        return {bg, fg, ch};
    endfunction

    // ------------------------------------------------------------------
    // Control word
    // ------------------------------------------------------------------
    typedef enum logic [2:0] {
        A_HOLD, A_INC, A_CURSOR, A_ZERO, A_COLS, A_BOTTOM, A_INDEX
    } addr_op_t;

    typedef enum logic [1:0] {
        L_HOLD, L_ROW_END, L_ALL
    } lim_op_t;

    typedef enum logic [2:0] {
        F_HOLD, F_ZERO, F_PUT, F_CLEAR, F_BLANK_LF, F_BLANK_SCR
    } fill_op_t;

    typedef enum logic [1:0] {
        M_NONE, M_WRITE_FILL, M_WRITE_COPY, M_READ
    } mem_op_t;

    typedef enum logic [1:0] {
        C_HOLD, C_COL_INC, C_COL_ZERO, C_ROW_INC
    } cur_op_t;

    // J_REPEAT: stay on this step while cells remain, then go to target.
    // J_MORE: go to target while cells remain, else fall through.
    typedef enum logic [2:0] {
        J_NEXT, J_ALWAYS, J_REPEAT, J_MORE, J_LINE_FEED, J_COL_LAST,
        J_ROW_LAST, J_DISPATCH
    } jump_t;

    localparam int STEP_W = 5;
    typedef logic [STEP_W-1:0] step_t;

    localparam step_t STEP_RST0   = 5'd0;
    localparam step_t STEP_RST1   = 5'd1;
    localparam step_t STEP_IDLE   = 5'd2;
    localparam step_t STEP_PUT0   = 5'd3;
    localparam step_t STEP_PUT1   = 5'd4;
    localparam step_t STEP_PUT2   = 5'd5;
    localparam step_t STEP_LF0    = 5'd6;
    localparam step_t STEP_LF1    = 5'd7;
    localparam step_t STEP_NL0    = 5'd8;
    localparam step_t STEP_NL1    = 5'd9;
    localparam step_t STEP_SCR0   = 5'd10;
    localparam step_t STEP_SCR1   = 5'd11;
    localparam step_t STEP_SCR2   = 5'd12;
    localparam step_t STEP_SCR3   = 5'd13;
    localparam step_t STEP_SCR4   = 5'd14;
    localparam step_t STEP_CLR0   = 5'd15;
    localparam step_t STEP_CLR1   = 5'd16;
    localparam step_t STEP_RD0    = 5'd17;
    localparam step_t STEP_RD1    = 5'd18;
    localparam step_t STEP_FINISH = 5'd19;

    typedef struct packed {
        addr_op_t addr_op;
        lim_op_t  lim_op;
        fill_op_t fill_op;
        mem_op_t  mem_op;
        cur_op_t  cur_op;
        logic     done;
        jump_t    jump;
        step_t    target;
    } uword_t;

    localparam uword_t UW_NOP = '{
        addr_op: A_HOLD, lim_op: L_HOLD, fill_op: F_HOLD, mem_op: M_NONE,
        cur_op: C_HOLD, done: 1'b0, jump: J_NEXT, target: STEP_IDLE
    };

    // Control store
    function automatic uword_t ucode(step_t s);
        uword_t w;
        w = UW_NOP;
        unique case (s)
            STEP_RST0: begin
                w.addr_op = A_ZERO;  w.lim_op = L_ALL;  w.fill_op = F_ZERO;
            end
            STEP_RST1: begin
                w.mem_op = M_WRITE_FILL;  w.addr_op = A_INC;
                w.jump = J_REPEAT;  w.target = STEP_IDLE;
            end
            STEP_IDLE: begin
                w.jump = J_DISPATCH;
            end
            STEP_PUT0: begin
                w.addr_op = A_CURSOR;  w.fill_op = F_PUT;
                w.jump = J_LINE_FEED;  w.target = STEP_LF0;
            end
            STEP_PUT1: begin
                w.mem_op = M_WRITE_FILL;
                w.jump = J_COL_LAST;  w.target = STEP_NL0;
            end
            STEP_PUT2: begin
                w.cur_op = C_COL_INC;
                w.jump = J_ALWAYS;  w.target = STEP_FINISH;
            end
            STEP_LF0: begin
                w.addr_op = A_CURSOR;  w.lim_op = L_ROW_END;  w.fill_op = F_BLANK_LF;
            end
            STEP_LF1: begin
                w.mem_op = M_WRITE_FILL;  w.addr_op = A_INC;
                w.jump = J_REPEAT;  w.target = STEP_NL0;
            end
            STEP_NL0: begin
                w.cur_op = C_COL_ZERO;
                w.jump = J_ROW_LAST;  w.target = STEP_SCR0;
            end
            STEP_NL1: begin
                w.cur_op = C_ROW_INC;
                w.jump = J_ALWAYS;  w.target = STEP_FINISH;
            end
            STEP_SCR0: begin
                w.addr_op = A_COLS;  w.lim_op = L_ALL;
            end
            STEP_SCR1: begin
                w.mem_op = M_READ;
            end
            STEP_SCR2: begin
                w.mem_op = M_WRITE_COPY;  w.addr_op = A_INC;
                w.jump = J_MORE;  w.target = STEP_SCR1;
            end
            STEP_SCR3: begin
                w.addr_op = A_BOTTOM;  w.fill_op = F_BLANK_SCR;
            end
            STEP_SCR4: begin
                w.mem_op = M_WRITE_FILL;  w.addr_op = A_INC;
                w.jump = J_REPEAT;  w.target = STEP_FINISH;
            end
            STEP_CLR0: begin
                w.addr_op = A_ZERO;  w.lim_op = L_ALL;  w.fill_op = F_CLEAR;
            end
            STEP_CLR1: begin
                w.mem_op = M_WRITE_FILL;  w.addr_op = A_INC;
                w.jump = J_REPEAT;  w.target = STEP_FINISH;
            end
            STEP_RD0: begin
                w.addr_op = A_INDEX;
            end
            STEP_RD1: begin
                w.mem_op = M_READ;
                w.jump = J_ALWAYS;  w.target = STEP_FINISH;
            end
            STEP_FINISH: begin
                w.done = 1'b1;
                w.jump = J_ALWAYS;  w.target = STEP_IDLE;
            end
            default: begin
                w.jump = J_ALWAYS;  w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

    // First step of each command
    function automatic step_t entry_step(logic [1:0] cmd);
        step_t s;
        unique case (cmd)
            CMD_PUT:   s = STEP_PUT0;
            CMD_CLEAR: s = STEP_CLR0;
            CMD_READ:  s = STEP_RD0;
            default:   s = STEP_FINISH;
        endcase
        return s;
    endfunction

endpackage

>>> rtl/text_mode_terminal_writer.sv
// ----------------------------------------------------------------------------
// text_mode_terminal_writer: text-cell store with cursor, line feed and scroll
// Microcoded sequencer over one cell memory (one write, one read per cycle).
// ----------------------------------------------------------------------------
// Put writes the cell at the cursor and steps it; read fetches one cell;
//   an unused command only strobes done; line feed blanks the rest of the row;
//   clear fills all R*C cells. A new line on the last row scrolls up a row.
// One item at a time, set by the sequencer; start is taken when busy
//   is low, also in the done cycle. Results strobe one cycle; no receiver stall.
// After reset the sequencer zeroes all R*C cells, with busy high meanwhile.
module text_mode_terminal_writer
    import tmtw_pkg::*;
#(
    parameter int NUM_COLUMNS = NUM_COLUMNS_DEF,
    parameter int NUM_ROWS    = NUM_ROWS_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  request_t request,
    output logic     busy,
    output logic     done,
    output result_t  result
);

    localparam int CELL_COUNT = NUM_ROWS * NUM_COLUMNS;
    localparam int AW         = $clog2(CELL_COUNT + 1);
    localparam int IDX_W      = $clog2(CELL_COUNT);
    localparam int ROW_W      = $clog2(NUM_ROWS);
    localparam int COL_W      = $clog2(NUM_COLUMNS);

    localparam logic [AW-1:0] ADDR_COLS   = AW'(NUM_COLUMNS);
    localparam logic [AW-1:0] ADDR_ALL    = AW'(CELL_COUNT);
    localparam logic [AW-1:0] ADDR_BOTTOM = AW'(CELL_COUNT - NUM_COLUMNS);
    localparam logic [COL_W-1:0] COL_LAST = COL_W'(NUM_COLUMNS - 1);
    localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(NUM_ROWS - 1);

    // Sequencer
    step_t    step_reg, step_next;
    uword_t   uw;

    // Datapath
    request_t          request_reg;
    logic [AW-1:0]     addr_reg, addr_next;
    logic [AW-1:0]     limit_reg, limit_next;
    logic [15:0]       fill_reg, fill_next;
    logic [ROW_W-1:0]  cursor_row_reg, cursor_row_next;
    logic [COL_W-1:0]  cursor_col_reg, cursor_col_next;
    logic [15:0]       rdata_reg;
    logic              done_reg;
    result_t           result_reg, result_next;

    logic [15:0]       text_mem [CELL_COUNT];

    logic              more;
    logic              accept;
    logic [AW-1:0]     row_base;
    logic [AW-1:0]     cursor_addr;
    logic [AW+10:0]    index_wide;
    logic              wr_en;
    logic              rd_en;
    logic [AW-1:0]     waddr;
    logic [15:0]       wdata;
    logic              read_ok;
    logic [ROW_W+4:0]  row_wide;
    logic [COL_W+6:0]  col_wide;

    assign uw     = ucode(step_reg);
    assign busy   = (step_reg != STEP_IDLE);
    assign accept = start && !busy;
    assign more   = (addr_reg + AW'(1)) != limit_reg;

    assign row_base    = AW'(cursor_row_reg) * ADDR_COLS;
    assign cursor_addr = row_base + AW'(cursor_col_reg);
    assign index_wide  = {{AW{1'b0}}, request_reg.cell_index};

    // Step counter
    always_comb
    begin
        unique case (uw.jump)
            J_NEXT:      step_next = step_reg + step_t'(1);
            J_ALWAYS:    step_next = uw.target;
            J_REPEAT:    step_next = more ? step_reg : uw.target;
            J_MORE:      step_next = more ? uw.target : step_reg + step_t'(1);
            J_LINE_FEED: step_next = (request_reg.char_code == LINE_FEED) ?
                                     uw.target : step_reg + step_t'(1);
            J_COL_LAST:  step_next = (cursor_col_reg == COL_LAST) ?
                                     uw.target : step_reg + step_t'(1);
            J_ROW_LAST:  step_next = (cursor_row_reg == ROW_LAST) ?
                                     uw.target : step_reg + step_t'(1);
            J_DISPATCH:  step_next = start ? entry_step(request.cmd) : STEP_IDLE;
            default:     step_next = STEP_IDLE;
        endcase
    end

    // Address, limit and fill word
    always_comb
    begin
        unique case (uw.addr_op)
            A_HOLD:   addr_next = addr_reg;
            A_INC:    addr_next = addr_reg + AW'(1);
            A_CURSOR: addr_next = cursor_addr;
            A_ZERO:   addr_next = '0;
            A_COLS:   addr_next = ADDR_COLS;
            A_BOTTOM: addr_next = ADDR_BOTTOM;
            A_INDEX:  addr_next = index_wide[AW-1:0];
            default:  addr_next = addr_reg;
        endcase

        unique case (uw.lim_op)
            L_HOLD:    limit_next = limit_reg;
            L_ROW_END: limit_next = row_base + ADDR_COLS;
            L_ALL:     limit_next = ADDR_ALL;
            default:   limit_next = limit_reg;
        endcase

        unique case (uw.fill_op)
            F_HOLD:      fill_next = fill_reg;
            F_ZERO:      fill_next = '0;
            F_PUT:       fill_next = make_cell(request_reg.char_code,
                                               request_reg.fg_color,
                                               request_reg.bg_color);
            F_CLEAR:     fill_next = make_cell(request_reg.char_code, WHITE_IDX,
                                               request_reg.bg_color);
            F_BLANK_LF:  fill_next = make_cell(SPACE_CHAR, WHITE_IDX, BLACK_IDX);
            F_BLANK_SCR: fill_next = make_cell(SPACE_CHAR, BLACK_IDX, WHITE_IDX);
            default:     fill_next = fill_reg;
        endcase
    end

    // Cursor
    always_comb
    begin
        cursor_row_next = cursor_row_reg;
        cursor_col_next = cursor_col_reg;
        unique case (uw.cur_op)
            C_HOLD:     ;
            C_COL_INC:  cursor_col_next = cursor_col_reg + COL_W'(1);
            C_COL_ZERO: cursor_col_next = '0;
            C_ROW_INC:  cursor_row_next = cursor_row_reg + ROW_W'(1);
            default:    ;
        endcase
    end

    // Memory port control: a copy beat moves the cell read last step up a row
    assign wr_en = (uw.mem_op == M_WRITE_FILL) || (uw.mem_op == M_WRITE_COPY);
    assign rd_en = (uw.mem_op == M_READ);
    assign waddr = (uw.mem_op == M_WRITE_COPY) ? (addr_reg - ADDR_COLS) : addr_reg;
    assign wdata = (uw.mem_op == M_WRITE_COPY) ? rdata_reg : fill_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            text_mem[waddr[IDX_W-1:0]] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= text_mem[addr_reg[IDX_W-1:0]];
        end
    end

    // Result beat
    assign read_ok  = (request_reg.cmd == CMD_READ) &&
                      (32'(request_reg.cell_index) < CELL_COUNT);
    assign row_wide = {5'b0, cursor_row_reg};
    assign col_wide = {7'b0, cursor_col_reg};

    always_comb
    begin
        result_next.read_data = read_ok ? rdata_reg : 16'h0000;
        result_next.row_now   = row_wide[4:0];
        result_next.col_now   = col_wide[6:0];
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg       <= STEP_RST0;
            cursor_row_reg <= '0;
            cursor_col_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            step_reg       <= step_next;
            cursor_row_reg <= cursor_row_next;
            cursor_col_reg <= cursor_col_next;
            done_reg       <= uw.done;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        limit_reg <= limit_next;
        fill_reg  <= fill_next;
        if (accept)
        begin
            request_reg <= request;
        end
        if (uw.done)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

`ifndef SYNTHESIS
    a_done_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(step_reg == STEP_FINISH))
        else $error("done strobe without a finish step");

    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result beat held for more than one cycle");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        (int'(cursor_col_reg) < NUM_COLUMNS) && (int'(cursor_row_reg) < NUM_ROWS))
        else $error("cursor outside the screen");

    a_write_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (int'(waddr) < CELL_COUNT))
        else $error("cell write outside the store");
`endif

endmodule
